// File: rtl/core/bpc_pkg.sv
// Package for the barometric pressure compensation core.
// Holds widths, reset coefficients, constants and the beat structs. No dependencies.
package bpc_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned RawW   = 16;
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgAc1   = 3'd0,
    CfgAc2   = 3'd1,
    CfgAc3   = 3'd2,
    CfgAc4   = 3'd3,
    CfgAc5   = 3'd4,
    CfgAc6   = 3'd5,
    CfgB1B2  = 3'd6,
    CfgMcMd  = 3'd7
  } cfg_idx_e;

  localparam logic [15:0] Ac1Rst  = 16'd408;
  localparam logic [15:0] Ac2Rst  = 16'hFFB8;
  localparam logic [15:0] Ac3Rst  = 16'hC7D1;
  localparam logic [15:0] Ac4Rst  = 16'd32741;
  localparam logic [15:0] Ac5Rst  = 16'd32757;
  localparam logic [15:0] Ac6Rst  = 16'd23153;
  localparam logic [31:0] B1B2Rst = 32'd405667844;
  localparam logic [31:0] McMdRst = 32'd3724086068;

  localparam logic [31:0] B6Off   = 32'd4000;
  localparam logic [31:0] K3038   = 32'd3038;
  localparam logic [31:0] KM7357  = 32'hFFFF_E343;
  localparam logic [31:0] K3791   = 32'd3791;
  localparam logic [31:0] K50000  = 32'd50000;
  localparam logic [31:0] K32768  = 32'd32768;

  localparam int unsigned QueueDepth = 2;

  // Calibration set, sign-extended where needed
  typedef struct packed {
    logic [31:0] ac1;
    logic [31:0] ac2;
    logic [31:0] ac3;
    logic [31:0] ac4;
    logic [31:0] ac5;
    logic [31:0] ac6;
    logic [31:0] b1;
    logic [31:0] b2;
    logic [31:0] mc;
    logic [31:0] md;
  } coef_t;

  // Beat passed from front to back
  typedef struct packed {
    logic [31:0] num;   // MC << 11
    logic [31:0] den;   // X1 + MD
    logic [31:0] x1;
    logic [15:0] up;
    logic        err;
  } front_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned s);
    return 32'($signed(x) >>> s);
  endfunction

endpackage

// File: rtl/core/barometric_pressure_compensation_core.sv
// Barometric pressure compensation core: takes one raw temperature/pressure
// beat per cycle and returns one compensated beat per input beat, through
// 2 front stages, 1 in the queue, two 32-stage pipelined dividers and 8 arithmetic
// stages including the output register. Throughput, set by the pipelined dividers,
// is one beat per cycle while out_ready does not stall the pipeline.
// Calibration registers are written through the cfg channel, always ready.
// Uses bpc_pkg, bpc_front, bpc_queue, bpc_back.
module barometric_pressure_compensation_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [bpc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] raw_temp_i,
  input  logic [15:0] raw_press_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] temp_tenths_o,
  output logic [31:0] press_pa_o,
  output logic        div_error_o
);
  import bpc_pkg::*;

  logic [15:0] ac1_q, ac2_q, ac3_q, ac4_q, ac5_q, ac6_q;
  logic [31:0] b1b2_q, mcmd_q;
  coef_t       coef;

  assign cfg_ready = 1'b1;

  // Calibration register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac1_q  <= Ac1Rst;
      ac2_q  <= Ac2Rst;
      ac3_q  <= Ac3Rst;
      ac4_q  <= Ac4Rst;
      ac5_q  <= Ac5Rst;
      ac6_q  <= Ac6Rst;
      b1b2_q <= B1B2Rst;
      mcmd_q <= McMdRst;
    end else if (cfg_valid) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgAc1:  ac1_q  <= cfg_data_i[15:0];
        CfgAc2:  ac2_q  <= cfg_data_i[15:0];
        CfgAc3:  ac3_q  <= cfg_data_i[15:0];
        CfgAc4:  ac4_q  <= cfg_data_i[15:0];
        CfgAc5:  ac5_q  <= cfg_data_i[15:0];
        CfgAc6:  ac6_q  <= cfg_data_i[15:0];
        CfgB1B2: b1b2_q <= cfg_data_i;
        CfgMcMd: mcmd_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    coef.ac1 = sx16(ac1_q);
    coef.ac2 = sx16(ac2_q);
    coef.ac3 = sx16(ac3_q);
    coef.ac4 = {16'd0, ac4_q};
    coef.ac5 = {16'd0, ac5_q};
    coef.ac6 = {16'd0, ac6_q};
    coef.b1  = sx16(b1b2_q[31:16]);
    coef.b2  = sx16(b1b2_q[15:0]);
    coef.mc  = sx16(mcmd_q[31:16]);
    coef.md  = sx16(mcmd_q[15:0]);
  end

  logic   fr_valid, fr_ready, bk_valid, bk_ready;
  front_t fr_beat, bk_beat;

  bpc_front u_front (
    .clk_i, .rst_ni, .coef_i(coef),
    .in_valid, .in_ready, .raw_temp_i, .raw_press_i,
    .fr_valid_o(fr_valid), .fr_ready_i(fr_ready), .fr_o(fr_beat)
  );

  bpc_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fr_valid), .wr_ready_o(fr_ready), .wr_data_i(fr_beat),
    .rd_valid_o(bk_valid), .rd_ready_i(bk_ready), .rd_data_o(bk_beat)
  );

  bpc_back u_back (
    .clk_i, .rst_ni, .coef_i(coef),
    .bk_valid_i(bk_valid), .bk_ready_o(bk_ready), .bk_i(bk_beat),
    .out_valid, .out_ready, .temp_tenths_o, .press_pa_o, .div_error_o
  );

endmodule

// File: rtl/core/bpc_divpipe.sv
// Pipelined 32-bit unsigned divider, one quotient bit per stage.
// Uses bpc_pkg. Carries a side payload alongside the operands.
module bpc_divpipe #(
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [31:0]      num_i,
  input  logic [31:0]      den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [31:0]      quo_o,
  output logic [SideW-1:0] side_o
);
  import bpc_pkg::*;

  localparam int unsigned Stages = 32;

  logic [Stages:0]      vld_q;
  logic [31:0]          rem_q  [Stages+1];
  logic [31:0]          quo_q  [Stages+1];
  logic [31:0]          den_q  [Stages+1];
  logic [SideW-1:0]     side_q [Stages+1];

  always_comb begin
    vld_q[0]  = valid_i;
    rem_q[0]  = '0;
    quo_q[0]  = num_i;
    den_q[0]  = den_i;
    side_q[0] = side_i;
  end

  // One restoring step per stage
  for (genvar g = 0; g < Stages; g++) begin : g_stage
    logic [32:0] trial;
    logic [31:0] rem_d;
    logic [31:0] quo_d;
    logic        vld_r;
    logic [31:0] rem_r, quo_r, den_r;
    logic [SideW-1:0] side_r;

    always_comb begin
      trial = {rem_q[g], quo_q[g][31]} - {1'b0, den_q[g]};
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[g][30:0], 1'b1};
      end else begin
        rem_d = {rem_q[g][30:0], quo_q[g][31]};
        quo_d = {quo_q[g][30:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_r <= 1'b0;
      end else if (en_i) begin
        vld_r <= vld_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_r  <= rem_d;
        quo_r  <= quo_d;
        den_r  <= den_q[g];
        side_r <= side_q[g];
      end
    end

    always_comb begin
      vld_q[g+1]  = vld_r;
      rem_q[g+1]  = rem_r;
      quo_q[g+1]  = quo_r;
      den_q[g+1]  = den_r;
      side_q[g+1] = side_r;
    end
  end

  assign valid_o = vld_q[Stages];
  assign quo_o   = quo_q[Stages];
  assign side_o  = side_q[Stages];

endmodule

// File: rtl/core/bpc_front.sv
// Front end: accepts raw beats, computes X1 and the temperature divisor.
// Uses bpc_pkg. Two register stages, stalls on the queue's ready.
module bpc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bpc_pkg::coef_t      coef_i,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [15:0]         raw_temp_i,
  input  logic [15:0]         raw_press_i,
  output logic                fr_valid_o,
  input  logic                fr_ready_i,
  output bpc_pkg::front_t     fr_o
);
  import bpc_pkg::*;

  logic        s1_vld_q, s2_vld_q;
  logic [31:0] s1_prod_q;
  logic [15:0] s1_up_q;
  front_t      s2_q, s2_d;
  logic        en;

  assign en       = fr_ready_i || !s2_vld_q;
  assign in_ready = en;

  // Stage 2 combinational: X1, divisor
  always_comb begin
    s2_d.x1  = asr(s1_prod_q, 15);
    s2_d.den = s2_d.x1 + coef_i.md;
    s2_d.num = coef_i.mc << 11;
    s2_d.up  = s1_up_q;
    s2_d.err = (s2_d.den == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid;
      s2_vld_q <= s1_vld_q;
    end
  end

  // Stage 1: (UT - AC6) * AC5
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_prod_q <= ({16'd0, raw_temp_i} - coef_i.ac6) * coef_i.ac5;
      s1_up_q   <= raw_press_i;
      s2_q      <= s2_d;
    end
  end

  assign fr_valid_o = s2_vld_q;
  assign fr_o       = s2_q;

endmodule

// File: rtl/core/bpc_queue.sv
// Short FIFO between the front and back ends.
// Uses bpc_pkg for the beat type.
module bpc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  bpc_pkg::front_t wr_data_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output bpc_pkg::front_t rd_data_o
);
  import bpc_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  front_t          mem_q [QueueDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;
  logic            wr, rd;

  assign wr_ready_o = (cnt_q != (PtrW+1)'(QueueDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == PtrW'(QueueDepth-1)) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (rp_q == PtrW'(QueueDepth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(wr) - (PtrW+1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

// File: rtl/core/bpc_back.sv
// Back end: temperature division, B3/B4/B7 math, pressure division, final fix.
// Uses bpc_pkg and bpc_divpipe. Whole pipeline stalls on the output ready.
module bpc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bpc_pkg::coef_t  coef_i,
  input  logic            bk_valid_i,
  output logic            bk_ready_o,
  input  bpc_pkg::front_t bk_i,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     temp_tenths_o,
  output logic [31:0]     press_pa_o,
  output logic            div_error_o
);
  import bpc_pkg::*;

  // Side payload of first divider: x1, up, err, sign of quotient
  localparam int unsigned Side1W = 32 + 16 + 1 + 1;
  // Side payload of second divider: t, err, post-doubling flag
  localparam int unsigned Side2W = 32 + 1 + 1;

  logic en;
  logic ovld_q;
  assign en         = out_ready || !ovld_q;
  assign bk_ready_o = en;

  // Temperature division on magnitudes
  logic        nneg, dneg;
  logic [31:0] mn, mdv, dsafe;
  always_comb begin
    nneg  = bk_i.num[31];
    dneg  = bk_i.den[31];
    mn    = nneg ? -bk_i.num : bk_i.num;
    mdv   = dneg ? -bk_i.den : bk_i.den;
    dsafe = bk_i.err ? 32'd1 : mdv;
  end

  logic             d1_vld;
  logic [31:0]      d1_q;
  logic [Side1W-1:0] d1_side;
  bpc_divpipe #(.SideW(Side1W)) u_div_t (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(bk_valid_i), .num_i(mn), .den_i(dsafe),
    .side_i({bk_i.x1, bk_i.up, bk_i.err, nneg ^ dneg}),
    .valid_o(d1_vld), .quo_o(d1_q), .side_o(d1_side)
  );

  // Stage A: B5, T, B6
  logic [31:0] a_x1, a_x2, a_b5;
  logic [15:0] a_up;
  logic        a_err;
  logic        sa_vld_q;
  logic [31:0] sa_t_q, sa_b6sqp_q, sa_ac2b6_q, sa_ac3b6_q;
  logic [15:0] sa_up_q;
  logic        sa_err_q;
  always_comb begin
    a_x1  = d1_side[Side1W-1 -: 32];
    a_up  = d1_side[17:2];
    a_err = d1_side[1];
    a_x2  = d1_side[0] ? -d1_q : d1_q;
    a_b5  = a_x1 + a_x2;
  end

  // Stage B: B6^2 >> 12 and products
  logic        sb_vld_q, sb_err_q;
  logic [31:0] sb_t_q, sb_b6sq_q, sb_ac2b6_q, sb_ac3b6_q;
  logic [15:0] sb_up_q;

  // Stage C: b2*b6sq, b1*b6sq
  logic        sc_vld_q, sc_err_q;
  logic [31:0] sc_t_q, sc_b2p_q, sc_b1p_q, sc_ac2b6_q, sc_ac3b6_q;
  logic [15:0] sc_up_q;

  // Stage D: B3, x3 for B4
  logic        sd_vld_q, sd_err_q;
  logic [31:0] sd_t_q, sd_b3_q, sd_x3_q;
  logic [15:0] sd_up_q;
  logic [31:0] d_x3a, d_n, d_b3, d_x3b;
  always_comb begin
    d_x3a = asr(sc_b2p_q, 11) + asr(sc_ac2b6_q, 11);
    d_n   = (coef_i.ac1 << 2) + d_x3a + 32'd2;
    // signed divide by 4, truncating toward zero
    d_b3  = asr(d_n + (d_n[31] ? 32'd3 : 32'd0), 2);
    d_x3b = asr(asr(sc_ac3b6_q, 13) + asr(sc_b1p_q, 16) + 32'd2, 2);
  end

  // Stage E: B4 product and B7 product
  logic        se_vld_q, se_err_q;
  logic [31:0] se_t_q, se_b4p_q, se_b7_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_vld_q <= 1'b0;
      sb_vld_q <= 1'b0;
      sc_vld_q <= 1'b0;
      sd_vld_q <= 1'b0;
      se_vld_q <= 1'b0;
    end else if (en) begin
      sa_vld_q <= d1_vld;
      sb_vld_q <= sa_vld_q;
      sc_vld_q <= sb_vld_q;
      sd_vld_q <= sc_vld_q;
      se_vld_q <= sd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_t_q     <= asr(a_b5 + 32'd8, 4);
      sa_up_q    <= a_up;
      sa_err_q   <= a_err;
      sa_b6sqp_q <= (a_b5 - B6Off) * (a_b5 - B6Off);
      sa_ac2b6_q <= coef_i.ac2 * (a_b5 - B6Off);
      sa_ac3b6_q <= coef_i.ac3 * (a_b5 - B6Off);

      sb_t_q     <= sa_t_q;
      sb_b6sq_q  <= asr(sa_b6sqp_q, 12);
      sb_ac2b6_q <= sa_ac2b6_q;
      sb_ac3b6_q <= sa_ac3b6_q;
      sb_up_q    <= sa_up_q;
      sb_err_q   <= sa_err_q;

      sc_t_q     <= sb_t_q;
      sc_b2p_q   <= coef_i.b2 * sb_b6sq_q;
      sc_b1p_q   <= coef_i.b1 * sb_b6sq_q;
      sc_ac2b6_q <= sb_ac2b6_q;
      sc_ac3b6_q <= sb_ac3b6_q;
      sc_up_q    <= sb_up_q;
      sc_err_q   <= sb_err_q;

      sd_t_q     <= sc_t_q;
      sd_b3_q    <= d_b3;
      sd_x3_q    <= d_x3b;
      sd_up_q    <= sc_up_q;
      sd_err_q   <= sc_err_q;

      se_t_q     <= sd_t_q;
      se_b4p_q   <= coef_i.ac4 * (sd_x3_q + K32768);
      se_b7_q    <= ({16'd0, sd_up_q} - sd_b3_q) * K50000;
      se_err_q   <= sd_err_q;
    end
  end

  // Pressure division setup
  logic [31:0] b4, pnum, pden;
  logic        perr, post2;
  always_comb begin
    b4    = se_b4p_q >> 15;
    perr  = se_err_q || (b4 == '0);
    post2 = se_b7_q[31];
    pnum  = post2 ? se_b7_q : (se_b7_q << 1);
    pden  = perr ? 32'd1 : b4;
  end

  logic              d2_vld;
  logic [31:0]       d2_q;
  logic [Side2W-1:0] d2_side;
  bpc_divpipe #(.SideW(Side2W)) u_div_p (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(se_vld_q), .num_i(pnum), .den_i(pden),
    .side_i({se_t_q, perr, post2}),
    .valid_o(d2_vld), .quo_o(d2_q), .side_o(d2_side)
  );

  // Stage F: p, p>>8 squared, -7357*p
  logic [31:0] f_p, f_p8;
  assign f_p  = d2_side[0] ? (d2_q << 1) : d2_q;
  assign f_p8 = asr(f_p, 8);

  logic        sf_vld_q, sf_err_q;
  logic [31:0] sf_t_q, sf_p_q, sf_sq_q, sf_x2_q;
  // Stage G: sq * 3038
  logic        sg_vld_q, sg_err_q;
  logic [31:0] sg_t_q, sg_p_q, sg_x1_q, sg_x2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sf_vld_q <= 1'b0;
      sg_vld_q <= 1'b0;
      ovld_q   <= 1'b0;
    end else if (en) begin
      sf_vld_q <= d2_vld;
      sg_vld_q <= sf_vld_q;
      ovld_q   <= sg_vld_q;
    end
  end

  logic [31:0] fin_p;
  assign fin_p = sg_p_q + asr(asr(sg_x1_q, 16) + asr(sg_x2_q, 16) + K3791, 4);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sf_t_q   <= d2_side[Side2W-1 -: 32];
      sf_err_q <= d2_side[1];
      sf_p_q   <= f_p;
      sf_sq_q  <= f_p8 * f_p8;
      sf_x2_q  <= KM7357 * f_p;

      sg_t_q   <= sf_t_q;
      sg_err_q <= sf_err_q;
      sg_p_q   <= sf_p_q;
      sg_x1_q  <= sf_sq_q * K3038;
      sg_x2_q  <= sf_x2_q;

      temp_tenths_o <= sg_err_q ? '0 : sg_t_q;
      press_pa_o    <= sg_err_q ? '0 : fin_p;
      div_error_o   <= sg_err_q;
    end
  end

  assign out_valid = ovld_q;

endmodule

// File: bench/barometric_pressure_compensation_core_tb.sv
// Testbench for barometric_pressure_compensation_core: a directed table, then random
// beats under several calibration sets, checked against an in-bench compensation predictor.
// Depends on bpc_pkg and the core RTL.
`timescale 1ns / 100ps

module barometric_pressure_compensation_core_tb;
  import bpc_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned RandPerPhase = 340;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] press;
    logic        err;
  } reading_t;

  typedef enum logic {RowBeat, RowReg} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [15:0] ut;
    logic [15:0] up;
    bit          typed;
    reading_t    want;
    cfg_idx_e    idx;
    logic [31:0] data;
  } row_t;

  logic clk_i, rst_ni;
  logic cfg_valid, cfg_ready;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [31:0] cfg_data_i;
  logic in_valid, in_ready;
  logic [15:0] raw_temp_i, raw_press_i;
  logic out_valid, out_ready;
  logic [31:0] temp_tenths_o, press_pa_o;
  logic div_error_o;

  barometric_pressure_compensation_core dut (.*);

  // Calibration copy kept by the bench
  logic [15:0] cal_ac1, cal_ac2, cal_ac3, cal_ac4, cal_ac5, cal_ac6;
  logic [31:0] cal_b1b2, cal_mcmd;

  reading_t readings_due[$];
  bit       typed_flag_q[$];
  reading_t typed_want_q[$];
  int unsigned n_fail;
  int unsigned cycles;
  int unsigned send_idle_pct, recv_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [31:0] sar(logic [31:0] v, int unsigned s);
    return $signed(v) >>> s;
  endfunction

  function automatic logic [31:0] ext16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Signed divide, truncating toward zero
  function automatic logic [31:0] div_trunc(logic [31:0] n, logic [31:0] d);
    logic [31:0] mn, md, q;
    mn = n[31] ? -n : n;
    md = d[31] ? -d : d;
    q = mn / md;
    return (n[31] != d[31]) ? -q : q;
  endfunction

  // Full temperature and pressure compensation for one beat
  function automatic reading_t compensate(logic [15:0] ut, logic [15:0] up);
    logic [31:0] x1, x2, x3, b5, b6, b6sq, b3, b4, b7, p, den, t;
    logic [31:0] b1, b2, mc, md;
    reading_t r;
    r = '{temp: '0, press: '0, err: 1'b1};
    b1 = ext16(cal_b1b2[31:16]);
    b2 = ext16(cal_b1b2[15:0]);
    mc = ext16(cal_mcmd[31:16]);
    md = ext16(cal_mcmd[15:0]);
    x1 = sar(({16'd0, ut} - {16'd0, cal_ac6}) * {16'd0, cal_ac5}, 15);
    den = x1 + md;
    if (den == 32'd0) return r;
    x2 = div_trunc(mc << 11, den);
    b5 = x1 + x2;
    t = sar(b5 + 32'd8, 4);
    b6 = b5 - 32'd4000;
    b6sq = sar(b6 * b6, 12);
    x1 = sar(b2 * b6sq, 11);
    x2 = sar(ext16(cal_ac2) * b6, 11);
    x3 = x1 + x2;
    b3 = div_trunc(ext16(cal_ac1) * 32'd4 + x3 + 32'd2, 32'd4);
    x1 = sar(ext16(cal_ac3) * b6, 13);
    x2 = sar(b1 * b6sq, 16);
    x3 = sar(x1 + x2 + 32'd2, 2);
    b4 = ({16'd0, cal_ac4} * (x3 + 32'd32768)) >> 15;
    if (b4 == 32'd0) return r;
    b7 = ({16'd0, up} - b3) * 32'd50000;
    // Unsigned divide; halve first when the doubled value would overflow
    if (!b7[31]) p = (b7 * 32'd2) / b4;
    else p = (b7 / b4) * 32'd2;
    x1 = sar(p, 8) * sar(p, 8);
    x1 = sar(x1 * 32'd3038, 16);
    x2 = sar(-32'd7357 * p, 16);
    p = p + sar(x1 + x2 + 32'd3791, 4);
    r = '{temp: t, press: p, err: 1'b0};
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %h, want %h", $realtime, what, got, want);
    n_fail++;
  endtask

  // Beat monitor, predictor hookup and scoreboard
  always @(posedge clk_i) begin
    reading_t w;
    if (rst_ni) begin
      cycles++;
      if (cycles > CycleLimit) begin
        $display("barometric_pressure_compensation_core: mismatch");
        $finish;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgAc1:  cal_ac1 = cfg_data_i[15:0];
          CfgAc2:  cal_ac2 = cfg_data_i[15:0];
          CfgAc3:  cal_ac3 = cfg_data_i[15:0];
          CfgAc4:  cal_ac4 = cfg_data_i[15:0];
          CfgAc5:  cal_ac5 = cfg_data_i[15:0];
          CfgAc6:  cal_ac6 = cfg_data_i[15:0];
          CfgB1B2: cal_b1b2 = cfg_data_i;
          CfgMcMd: cal_mcmd = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (typed_flag_q.pop_front()) readings_due.push_back(typed_want_q.pop_front());
        else readings_due.push_back(compensate(raw_temp_i, raw_press_i));
      end
      if (out_valid && out_ready) begin
        if (readings_due.size() == 0) begin
          report("unexpected beat", temp_tenths_o, 32'd0);
        end else begin
          w = readings_due.pop_front();
          if (temp_tenths_o !== w.temp) report("temp_tenths", temp_tenths_o, w.temp);
          if (press_pa_o !== w.press) report("press_pa", press_pa_o, w.press);
          if (div_error_o !== w.err) report("div_error", {31'd0, div_error_o}, {31'd0, w.err});
        end
      end
    end
  end

  // Receiver stall pattern
  always @(negedge clk_i) begin
    out_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  // Caller is at a falling edge; returns at the falling edge after acceptance
  task automatic send_beat(logic [15:0] ut, logic [15:0] up, bit typed, reading_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    typed_flag_q.push_back(typed);
    if (typed) typed_want_q.push_back(want);
    in_valid = 1'b1;
    raw_temp_i = ut;
    raw_press_i = up;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  // Let the pipeline empty before touching calibration
  task automatic drain();
    in_valid = 1'b0;
    while (readings_due.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    cfg_valid = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all(logic [15:0] a1, a2, a3, a4, a5, a6, logic [31:0] bb, mm);
    write_reg(CfgAc1, {16'($urandom_range(65535)), a1});
    write_reg(CfgAc2, {16'($urandom_range(65535)), a2});
    write_reg(CfgAc3, {16'($urandom_range(65535)), a3});
    write_reg(CfgAc4, {16'($urandom_range(65535)), a4});
    write_reg(CfgAc5, {16'($urandom_range(65535)), a5});
    write_reg(CfgAc6, {16'($urandom_range(65535)), a6});
    write_reg(CfgB1B2, bb);
    write_reg(CfgMcMd, mm);
  endtask

  // Mostly plausible sensor words, some full-range and some rail values
  task automatic random_beats(int unsigned n);
    logic [15:0] ut, up;
    int unsigned pick;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        ut = 16'($urandom_range(36000, 20000));
        up = 16'($urandom_range(45000, 15000));
      end else if (pick < 92) begin
        ut = 16'($urandom_range(65535));
        up = 16'($urandom_range(65535));
      end else begin
        ut = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        up = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      end
      send_beat(ut, up, 1'b0, '0);
    end
  endtask

  row_t rows[$];
  reading_t fault;

  function automatic row_t beat_row(logic [15:0] ut, logic [15:0] up, bit typed, reading_t w);
    row_t r;
    r = '{kind: RowBeat, ut: ut, up: up, typed: typed, want: w, idx: CfgAc1, data: '0};
    return r;
  endfunction

  function automatic row_t reg_row(cfg_idx_e idx, logic [31:0] data);
    row_t r;
    r = '{kind: RowReg, ut: '0, up: '0, typed: 1'b0, want: '0, idx: idx, data: data};
    return r;
  endfunction

  initial begin
    cal_ac1 = Ac1Rst; cal_ac2 = Ac2Rst; cal_ac3 = Ac3Rst;
    cal_ac4 = Ac4Rst; cal_ac5 = Ac5Rst; cal_ac6 = Ac6Rst;
    cal_b1b2 = B1B2Rst; cal_mcmd = McMdRst;
    n_fail = 0;
    cycles = 0;
    send_idle_pct = 25;
    recv_idle_pct = 63;
    rst_ni = 1'b0;
    cfg_valid = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid = 1'b0;
    raw_temp_i = '0;
    raw_press_i = '0;
    out_ready = 1'b0;
    fault = '{temp: '0, press: '0, err: 1'b1};

    // Directed table: reset coefficients, field extremes, both zero divisors
    rows.push_back(beat_row(16'd27898, 16'd23843, 1'b1,
                            '{temp: 32'd150, press: 32'd69964, err: 1'b0}));
    rows.push_back(beat_row(16'h0000, 16'h0000, 1'b0, '0));
    rows.push_back(beat_row(16'hFFFF, 16'hFFFF, 1'b0, '0));
    rows.push_back(beat_row(16'h0000, 16'hFFFF, 1'b0, '0));
    rows.push_back(beat_row(16'hFFFF, 16'h0000, 1'b0, '0));
    rows.push_back(beat_row(16'h5555, 16'hAAAA, 1'b0, '0));
    rows.push_back(beat_row(16'hAAAA, 16'h5555, 1'b0, '0));
    rows.push_back(beat_row(16'd23153, 16'd40000, 1'b0, '0));
    rows.push_back(beat_row(16'h8000, 16'h7FFF, 1'b0, '0));
    // temperature divisor zero: MD = 0 and UT = AC6 gives X1 + MD = 0
    rows.push_back(reg_row(CfgMcMd, 32'hDDF9_0000));
    rows.push_back(beat_row(16'd23153, 16'd23843, 1'b1, fault));
    rows.push_back(beat_row(16'd23153, 16'hFFFF, 1'b1, fault));
    rows.push_back(beat_row(16'd27898, 16'd23843, 1'b0, '0));
    // pressure divisor zero: AC4 = 0 forces B4 = 0
    rows.push_back(reg_row(CfgMcMd, McMdRst));
    rows.push_back(reg_row(CfgAc4, 32'd0));
    rows.push_back(beat_row(16'd27898, 16'd23843, 1'b1, fault));
    rows.push_back(beat_row(16'hFFFF, 16'h0000, 1'b1, fault));
    rows.push_back(reg_row(CfgAc4, {16'd0, Ac4Rst}));
    rows.push_back(beat_row(16'd30000, 16'd30000, 1'b0, '0));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind == RowReg) begin
        drain();
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        send_beat(rows[i].ut, rows[i].up, rows[i].typed, rows[i].want);
      end
    end

    // Phase 1: reset-like calibration, sender idles 25%, receiver 63%
    random_beats(RandPerPhase);

    // Phase 2: negative and full-scale extremes, idling swapped
    drain();
    write_all(16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              32'h8000_8000, 32'h8000_7FFF);
    send_idle_pct = 63;
    recv_idle_pct = 25;
    random_beats(RandPerPhase / 2);
    drain();
    write_all(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0001, 16'h0000, 16'h0000,
              32'h7FFF_7FFF, 32'h7FFF_8000);
    random_beats(RandPerPhase / 2);

    // Phase 3: random calibration sets, no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) begin
      drain();
      write_all(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                16'($urandom_range(65535)), 16'($urandom_range(65535)),
                16'($urandom_range(65535)), 16'($urandom_range(65535)),
                $urandom(), $urandom());
      random_beats(RandPerPhase / 4);
    end

    drain();
    if (n_fail == 0) begin
      $display("barometric_pressure_compensation_core: match");
    end else begin
      $display("barometric_pressure_compensation_core: mismatch");
    end
    $finish;
  end

endmodule

// File: barometric_pressure_compensation_core.f
rtl/core/bpc_pkg.sv
rtl/core/bpc_divpipe.sv
rtl/core/bpc_front.sv
rtl/core/bpc_queue.sv
rtl/core/bpc_back.sv
rtl/core/barometric_pressure_compensation_core.sv
bench/barometric_pressure_compensation_core_tb.sv
